// ===== rtl/core/pfa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfa_pkg
// shared types and constants of the page frame allocator
// ----------------------------------------------------------------------------
package pfa_pkg;

  localparam int unsigned ADDR_W         = 32;
  localparam int unsigned COUNT_W        = 21;
  localparam int unsigned BASE_W         = 20;
  localparam int unsigned STATUS_W       = 2;
  localparam int unsigned DEF_FREE_DEPTH = 1024;
  localparam int unsigned DEF_PAGE_SHIFT = 12;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK          = 2'd0,
    STATUS_NONE_IN_USE = 2'd1,
    STATUS_STORE_FULL  = 2'd2,
    STATUS_EXHAUSTED   = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CMD_REJECT = 2'd0,
    CMD_PUSH   = 2'd1,
    CMD_POP    = 2'd2,
    CMD_BUMP   = 2'd3
  } cmd_e;

  typedef struct packed {
    logic    load;
    cmd_e    op;
    logic    reserve;
    status_e status;
  } pfa_cmd_t;

  typedef struct packed {
    logic reserved;
    logic frame_avail;
    logic frame_avail2;
    logic free_empty;
    logic free_full;
    logic none_in_use;
  } pfa_stat_t;

endpackage

// ===== rtl/core/page_frame_allocator_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// page_frame_allocator_unit
// page frame allocator with bump pointer and lifo free stack
// ----------------------------------------------------------------------------
// result: valid in the cycle after its request transfer
// throughput: one request per cycle when not stalled, set by the single-port
//   free stack memory whose registered read data drives the result of a pop
// reset: counters, reservation flag and bump pointer clear at once, the free
//   stack memory is not cleared; no clearing pass, requests taken right away
module page_frame_allocator_unit
  import pfa_pkg::*;
#(
  parameter int unsigned FREE_DEPTH = DEF_FREE_DEPTH,
  parameter int unsigned PAGE_SHIFT = DEF_PAGE_SHIFT
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [BASE_W-1:0]   cfg_base_frame_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                in_operation_i,
  input  logic [ADDR_W-1:0]   in_free_address_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [ADDR_W-1:0]   out_page_address_o,
  output logic [COUNT_W-1:0]  out_pages_in_use_o,
  output logic [STATUS_W-1:0] out_status_o
);

  pfa_cmd_t  cmd;
  pfa_stat_t stat;

  assign cfg_ready_o = 1'b1;

  pfa_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .in_operation_i (in_operation_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .stat_i         (stat),
    .cmd_o          (cmd)
  );

  pfa_datapath #(
    .FREE_DEPTH (FREE_DEPTH),
    .PAGE_SHIFT (PAGE_SHIFT)
  ) u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_valid_i && cfg_ready_o),
    .cfg_base_frame_i   (cfg_base_frame_i),
    .cmd_i              (cmd),
    .in_free_address_i  (in_free_address_i),
    .stat_o             (stat),
    .out_page_address_o (out_page_address_o),
    .out_pages_in_use_o (out_pages_in_use_o),
    .out_status_o       (out_status_o)
  );

`ifndef SYNTHESIS
  a_accept_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> out_valid_o)
    else $error("request transfer without result");

  a_fail_zero_address: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_status_o != STATUS_OK) |-> (out_page_address_o == '0))
    else $error("failed request with nonzero address");

  a_none_in_use_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_status_o == STATUS_NONE_IN_USE) |-> (out_pages_in_use_o == '0))
    else $error("free rejected with pages in use");
`endif

endmodule

// ===== rtl/core/pfa_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfa_ctrl
// request decode and output register handshake of the allocator
// ----------------------------------------------------------------------------
module pfa_ctrl
  import pfa_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  logic      in_operation_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  input  pfa_stat_t stat_i,
  output pfa_cmd_t  cmd_o
);

  localparam logic ST_EMPTY = 1'b0;
  localparam logic ST_FULL  = 1'b1;

  logic state_q, state_d;
  logic can_load;
  logic accept;

  assign can_load   = (state_q == ST_EMPTY) || !out_stall_i;
  assign accept     = in_valid_i && can_load;
  assign in_stall_o = !can_load;
  assign out_valid_o = (state_q == ST_FULL);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_EMPTY: begin
        if (accept) state_d = ST_FULL;
      end
      ST_FULL: begin
        if (!out_stall_i && !accept) state_d = ST_EMPTY;
      end
      default: state_d = ST_EMPTY;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_EMPTY;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    cmd_o.load    = accept;
    cmd_o.op      = CMD_REJECT;
    cmd_o.reserve = 1'b0;
    cmd_o.status  = STATUS_OK;
    if (in_operation_i == OP_FREE) begin
      if (stat_i.none_in_use) begin
        cmd_o.status = STATUS_NONE_IN_USE;
      end else if (stat_i.free_full) begin
        cmd_o.status = STATUS_STORE_FULL;
      end else begin
        cmd_o.op = CMD_PUSH;
      end
    end else if (!stat_i.reserved) begin
      if (!stat_i.frame_avail) begin
        cmd_o.status = STATUS_EXHAUSTED;
      end else begin
        cmd_o.reserve = 1'b1;
        if (!stat_i.free_empty) begin
          cmd_o.op = CMD_POP;
        end else if (stat_i.frame_avail2) begin
          cmd_o.op = CMD_BUMP;
        end else begin
          cmd_o.status = STATUS_EXHAUSTED;
        end
      end
    end else if (!stat_i.free_empty) begin
      cmd_o.op = CMD_POP;
    end else if (stat_i.frame_avail) begin
      cmd_o.op = CMD_BUMP;
    end else begin
      cmd_o.status = STATUS_EXHAUSTED;
    end
  end

endmodule

// ===== rtl/core/pfa_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfa_datapath
// bump pointer, free stack memory, page counter and result registers
// ----------------------------------------------------------------------------
module pfa_datapath
  import pfa_pkg::*;
#(
  parameter int unsigned FREE_DEPTH = DEF_FREE_DEPTH,
  parameter int unsigned PAGE_SHIFT = DEF_PAGE_SHIFT
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [BASE_W-1:0]   cfg_base_frame_i,
  input  pfa_cmd_t            cmd_i,
  input  logic [ADDR_W-1:0]   in_free_address_i,
  output pfa_stat_t           stat_o,
  output logic [ADDR_W-1:0]   out_page_address_o,
  output logic [COUNT_W-1:0]  out_pages_in_use_o,
  output logic [STATUS_W-1:0] out_status_o
);

  localparam int unsigned AW          = $clog2(FREE_DEPTH);
  localparam int unsigned FC_W        = AW + 1;
  localparam int unsigned LIMIT_W     = ADDR_W + 1 - PAGE_SHIFT;
  localparam int unsigned FRAME_W     = (LIMIT_W > BASE_W + 1) ? LIMIT_W : BASE_W + 1;
  localparam int unsigned FRAME_LIMIT = 1 << (ADDR_W - PAGE_SHIFT);

  logic [ADDR_W-1:0]  mem [FREE_DEPTH];
  logic [ADDR_W-1:0]  rdata_q;

  logic [FRAME_W-1:0] next_q, next_d;
  logic [FC_W-1:0]    free_cnt_q, free_cnt_d;
  logic [FRAME_W-1:0] in_use_q, in_use_d;
  logic               reserved_q, reserved_d;

  logic               pop_q;
  logic [ADDR_W-1:0]  addr_q, addr_d;
  logic [FRAME_W-1:0] cnt_out_q;
  logic [STATUS_W-1:0] status_q;

  logic [FRAME_W-1:0] frame_sel;
  logic               do_push, do_pop;
  logic [FC_W-1:0]    pop_idx;

  assign stat_o.reserved     = reserved_q;
  assign stat_o.frame_avail  = next_q < FRAME_W'(FRAME_LIMIT);
  assign stat_o.frame_avail2 = next_q < FRAME_W'(FRAME_LIMIT - 1);
  assign stat_o.free_empty   = (free_cnt_q == '0);
  assign stat_o.free_full    = (free_cnt_q >= FC_W'(FREE_DEPTH));
  assign stat_o.none_in_use  = (in_use_q == '0);

  assign do_push   = cmd_i.load && (cmd_i.op == CMD_PUSH);
  assign do_pop    = cmd_i.load && (cmd_i.op == CMD_POP);
  assign pop_idx   = free_cnt_q - FC_W'(1);
  assign frame_sel = next_q + FRAME_W'(cmd_i.reserve);

  always_comb begin
    next_d     = next_q;
    free_cnt_d = free_cnt_q;
    in_use_d   = in_use_q;
    reserved_d = reserved_q;
    addr_d     = '0;
    if (cmd_i.load) begin
      if (cmd_i.reserve) reserved_d = 1'b1;
      case (cmd_i.op)
        CMD_PUSH: begin
          free_cnt_d = free_cnt_q + FC_W'(1);
          in_use_d   = in_use_q - FRAME_W'(1);
        end
        CMD_POP: begin
          free_cnt_d = pop_idx;
          in_use_d   = in_use_q + FRAME_W'(1);
          next_d     = frame_sel;
        end
        CMD_BUMP: begin
          in_use_d = in_use_q + FRAME_W'(1);
          next_d   = frame_sel + FRAME_W'(1);
          addr_d   = ADDR_W'(frame_sel) << PAGE_SHIFT;
        end
        default: begin
          next_d = frame_sel;
        end
      endcase
    end
    if (cfg_we_i) next_d = FRAME_W'(cfg_base_frame_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      next_q     <= '0;
      free_cnt_q <= '0;
      in_use_q   <= '0;
      reserved_q <= 1'b0;
    end else begin
      next_q     <= next_d;
      free_cnt_q <= free_cnt_d;
      in_use_q   <= in_use_d;
      reserved_q <= reserved_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem[free_cnt_q[AW-1:0]] <= in_free_address_i;
    if (do_pop) rdata_q <= mem[pop_idx[AW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      pop_q     <= (cmd_i.op == CMD_POP);
      addr_q    <= addr_d;
      cnt_out_q <= in_use_d;
      status_q  <= cmd_i.status;
    end
  end

  assign out_page_address_o = pop_q ? rdata_q : addr_q;
  assign out_pages_in_use_o = cnt_out_q[COUNT_W-1:0];
  assign out_status_o       = status_q;

endmodule
